>>> rtl/core/u8af_pkg.sv
// Shared types, constants and the accent folding table for the UTF-8 folder.
package u8af_pkg;

    localparam int FoldCount = 145;
    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = $clog2(FifoDepth);
    localparam int FifoCntW  = $clog2(FifoDepth + 1);

    localparam logic [7:0]  AsciiLimit    = 8'h80;
    localparam logic [7:0]  LeadMask2     = 8'hE0;
    localparam logic [7:0]  Lead2         = 8'hC0;
    localparam logic [7:0]  LeadMask3     = 8'hF0;
    localparam logic [7:0]  Lead3         = 8'hE0;
    localparam logic [7:0]  LeadMask4     = 8'hF8;
    localparam logic [7:0]  Lead4         = 8'hF0;
    localparam logic [7:0]  CharUnknown   = 8'h3F;
    localparam logic [7:0]  CharNul       = 8'h00;
    localparam logic [15:0] OutLimitReset = 16'hFFFF;

    localparam logic [2:0] SeqNone = 3'd0;
    localparam logic [2:0] Seq2    = 3'd2;
    localparam logic [2:0] Seq3    = 3'd3;
    localparam logic [2:0] Seq4    = 3'd4;
    localparam logic [2:0] SeqKept = 3'd3;

    typedef struct packed {
        logic [15:0] cp;
        logic [7:0]  ch;
    } t_fold_entry;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_string;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    localparam t_fold_entry FoldTable [FoldCount] = '{
        '{16'h00E0, "a"}, '{16'h00E1, "a"}, '{16'h1EA3, "a"}, '{16'h00E3, "a"},
        '{16'h1EA1, "a"},
        '{16'h0103, "a"}, '{16'h1EB1, "a"}, '{16'h1EAF, "a"}, '{16'h1EB3, "a"},
        '{16'h1EB5, "a"}, '{16'h1EB7, "a"},
        '{16'h00E2, "a"}, '{16'h1EA7, "a"}, '{16'h1EA5, "a"}, '{16'h1EA9, "a"},
        '{16'h1EAB, "a"}, '{16'h1EAD, "a"},
        '{16'h00E8, "e"}, '{16'h00E9, "e"}, '{16'h1EBB, "e"}, '{16'h1EBD, "e"},
        '{16'h1EB9, "e"},
        '{16'h00EA, "e"}, '{16'h1EC1, "e"}, '{16'h1EBF, "e"}, '{16'h1EC3, "e"},
        '{16'h1EC5, "e"}, '{16'h1EC7, "e"},
        '{16'h00EC, "i"}, '{16'h00ED, "i"}, '{16'h1EC9, "i"}, '{16'h0129, "i"},
        '{16'h1ECB, "i"},
        '{16'h00F2, "o"}, '{16'h00F3, "o"}, '{16'h1ECF, "o"}, '{16'h00F5, "o"},
        '{16'h1ECD, "o"},
        '{16'h00F4, "o"}, '{16'h1ED3, "o"}, '{16'h1ED1, "o"}, '{16'h1ED5, "o"},
        '{16'h1ED7, "o"}, '{16'h1ED9, "o"},
        '{16'h01A1, "o"}, '{16'h1EDD, "o"}, '{16'h1EDB, "o"}, '{16'h1EDF, "o"},
        '{16'h1EE1, "o"}, '{16'h1EE3, "o"},
        '{16'h00F9, "u"}, '{16'h00FA, "u"}, '{16'h1EE7, "u"}, '{16'h0169, "u"},
        '{16'h1EE5, "u"},
        '{16'h01B0, "u"}, '{16'h1EEB, "u"}, '{16'h1EE9, "u"}, '{16'h1EED, "u"},
        '{16'h1EEF, "u"}, '{16'h1EF1, "u"},
        '{16'h1EF3, "y"}, '{16'h00FD, "y"}, '{16'h1EF7, "y"}, '{16'h1EF9, "y"},
        '{16'h1EF5, "y"},
        '{16'h0111, "d"},
        '{16'h00C0, "A"}, '{16'h00C1, "A"}, '{16'h1EA2, "A"}, '{16'h00C3, "A"},
        '{16'h1EA0, "A"},
        '{16'h0102, "A"}, '{16'h1EB0, "A"}, '{16'h1EAE, "A"}, '{16'h1EB2, "A"},
        '{16'h1EB4, "A"}, '{16'h1EB6, "A"},
        '{16'h00C2, "A"}, '{16'h1EA6, "A"}, '{16'h1EA4, "A"}, '{16'h1EA8, "A"},
        '{16'h1EAA, "A"}, '{16'h1EAC, "A"},
        '{16'h00C8, "E"}, '{16'h00C9, "E"}, '{16'h1EBA, "E"}, '{16'h1EBC, "E"},
        '{16'h1EB8, "E"},
        '{16'h00CA, "E"}, '{16'h1EC0, "E"}, '{16'h1EBE, "E"}, '{16'h1EC2, "E"},
        '{16'h1EC4, "E"}, '{16'h1EC6, "E"},
        '{16'h00CC, "I"}, '{16'h00CD, "I"}, '{16'h1EC8, "I"}, '{16'h0128, "I"},
        '{16'h1ECA, "I"},
        '{16'h00D2, "O"}, '{16'h00D3, "O"}, '{16'h1ECE, "O"}, '{16'h00D5, "O"},
        '{16'h1ECC, "O"},
        '{16'h00D4, "O"}, '{16'h1ED2, "O"}, '{16'h1ED0, "O"}, '{16'h1ED4, "O"},
        '{16'h1ED6, "O"}, '{16'h1ED8, "O"},
        '{16'h01A0, "O"}, '{16'h1EDC, "O"}, '{16'h1EDA, "O"}, '{16'h1EDE, "O"},
        '{16'h1EE0, "O"}, '{16'h1EE2, "O"},
        '{16'h00D9, "U"}, '{16'h00DA, "U"}, '{16'h1EE6, "U"}, '{16'h0168, "U"},
        '{16'h1EE4, "U"},
        '{16'h01AF, "U"}, '{16'h1EEA, "U"}, '{16'h1EE8, "U"}, '{16'h1EEC, "U"},
        '{16'h1EEE, "U"}, '{16'h1EF0, "U"},
        '{16'h1EF2, "Y"}, '{16'h00DD, "Y"}, '{16'h1EF6, "Y"}, '{16'h1EF8, "Y"},
        '{16'h1EF4, "Y"},
        '{16'h0110, "D"},
        '{16'h00E4, "a"}, '{16'h00F6, "o"}, '{16'h00FC, "u"}, '{16'h00DF, "s"},
        '{16'h00C4, "A"}, '{16'h00D6, "O"}, '{16'h00DC, "U"},
        '{16'h00E7, "c"}, '{16'h00C7, "C"},
        '{16'h00F1, "n"}, '{16'h00D1, "N"}
    };

    // UTF-8 byte form of a code point, right aligned in 24 bits.
    function automatic logic [23:0] fold_key(input logic [15:0] cp);
        logic [23:0] key;
        if (cp < 16'h0800) begin
            key = {8'h00, 3'b110, cp[10:6], 2'b10, cp[5:0]};
        end else begin
            key = {4'hE, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
        end
        return key;
    endfunction

endpackage

>>> rtl/core/u8af_in_if.sv
// Byte input channel: valid, ready and one UTF-8 byte.
interface u8af_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

>>> rtl/core/u8af_out_if.sv
// Result output channel: valid, ready, folded character and end of string flag.
interface u8af_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       end_of_string;

    modport source (output valid, output out_char, output end_of_string, input ready);
    modport sink (input valid, input out_char, input end_of_string, output ready);
endinterface

>>> rtl/core/u8af_fold_lut.sv
// Parallel match of a gathered sequence against the accent folding table.
module u8af_fold_lut
    import u8af_pkg::*;
(
    input  logic [23:0] i_key,
    output logic [7:0]  o_char
);

    always_comb begin
        o_char = CharUnknown;
        for (int i = FoldCount - 1; i >= 0; i--) begin
            if (i_key == fold_key(FoldTable[i].cp)) begin
                o_char = FoldTable[i].ch;
            end
        end
    end

endmodule

>>> rtl/core/u8af_seq.sv
// Sequence gathering, output limit and result generation for each byte.
module u8af_seq
    import u8af_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    output t_push       o_push
);

    logic [15:0] r_gathered, n_gathered;
    logic [2:0]  r_seq_len, n_seq_len;
    logic [1:0]  r_remaining, n_remaining;
    logic [15:0] r_chars, n_chars;
    logic [15:0] r_out_limit;

    logic [7:0]  w_fold_char;
    logic        w_emit;
    logic        w_term;
    logic        w_do_emit;
    logic [7:0]  w_emit_char;

    u8af_fold_lut u_lut (
        .i_key  ({r_gathered, i_byte}),
        .o_char (w_fold_char)
    );

    always_comb begin
        n_gathered  = r_gathered;
        n_seq_len   = r_seq_len;
        n_remaining = r_remaining;
        w_emit      = 1'b0;
        w_term      = 1'b0;
        w_emit_char = CharUnknown;
        if (i_accept) begin
            if (i_byte == CharNul) begin
                w_emit      = (r_seq_len != SeqNone);
                w_term      = 1'b1;
                n_seq_len   = SeqNone;
                n_remaining = 2'd0;
            end else if (r_seq_len == SeqNone) begin
                n_gathered = {8'h00, i_byte};
                if (i_byte < AsciiLimit) begin
                    w_emit      = 1'b1;
                    w_emit_char = i_byte;
                end else if ((i_byte & LeadMask2) == Lead2) begin
                    n_seq_len   = Seq2;
                    n_remaining = 2'd1;
                end else if ((i_byte & LeadMask3) == Lead3) begin
                    n_seq_len   = Seq3;
                    n_remaining = 2'd2;
                end else if ((i_byte & LeadMask4) == Lead4) begin
                    n_seq_len   = Seq4;
                    n_remaining = 2'd3;
                end else begin
                    w_emit = 1'b1;
                end
            end else begin
                if ((r_seq_len - {1'b0, r_remaining}) < SeqKept) begin
                    n_gathered = {r_gathered[7:0], i_byte};
                end
                n_remaining = r_remaining - 2'd1;
                if (r_remaining == 2'd1) begin
                    w_emit      = 1'b1;
                    n_seq_len   = SeqNone;
                    if (r_seq_len == Seq2 || r_seq_len == Seq3) begin
                        w_emit_char = w_fold_char;
                    end
                end
            end
        end
        w_do_emit = w_emit && (r_chars < r_out_limit);
        if (w_term) begin
            n_chars = 16'd0;
        end else if (w_do_emit) begin
            n_chars = r_chars + 16'd1;
        end else begin
            n_chars = r_chars;
        end
    end

    always_comb begin
        o_push.count  = {1'b0, w_do_emit} + {1'b0, w_term};
        o_push.second = '{out_char: CharNul, end_of_string: 1'b1};
        if (w_do_emit) begin
            o_push.first = '{out_char: w_emit_char, end_of_string: 1'b0};
        end else begin
            o_push.first = '{out_char: CharNul, end_of_string: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len   <= SeqNone;
            r_remaining <= 2'd0;
            r_chars     <= 16'd0;
            r_out_limit <= OutLimitReset;
        end else begin
            r_seq_len   <= n_seq_len;
            r_remaining <= n_remaining;
            r_chars     <= n_chars;
            if (i_cfg_wr_en) begin
                r_out_limit <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gathered <= n_gathered;
    end

endmodule

>>> rtl/core/u8af_out_fifo.sv
// Small result queue taking up to two results per cycle and giving one.
module u8af_out_fifo
    import u8af_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_push               i_push,
    output logic                o_valid,
    input  logic                i_ready,
    output t_result             o_data,
    output logic [FifoCntW-1:0] o_count
);

    t_result               r_mem [FifoDepth];
    logic [FifoPtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FifoPtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FifoCntW-1:0]   r_count, n_count;
    logic                  w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + FifoPtrW'(i_push.count);
        n_rd_ptr = r_rd_ptr + FifoPtrW'(w_pop);
        n_count  = r_count + FifoCntW'(i_push.count) - FifoCntW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + FifoPtrW'(1)] <= i_push.second;
        end
    end

endmodule

>>> rtl/core/utf8_accent_fold_to_ascii.sv
// Top level of the UTF-8 accent folder.
// Takes one UTF-8 byte per cycle and gives folded ASCII characters through
// a four-entry result queue. ASCII bytes pass through; a 2 or
// 3 byte sequence that names a known accented letter gives its base letter,
// any other sequence or stray byte gives '?'. A zero byte gives a terminator
// transaction (end_of_string high, out_char zero), preceded by '?' when a
// sequence was left open, so one byte causes 0, 1 or 2 transactions. At most
// out_limit characters are given per string. The input is ready whenever the
// queue has two free entries, so with the output side taking every cycle the
// block sustains one byte per cycle; the table match sits between the
// sequence registers and the queue.
module utf8_accent_fold_to_ascii
    import u8af_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    u8af_in_if.sink     i_in,
    u8af_out_if.source  o_out
);

    t_push               w_push;
    t_result             w_head;
    logic [FifoCntW-1:0] w_fifo_count;
    logic                w_accept;

    assign i_in.ready = (w_fifo_count <= FifoCntW'(FifoDepth - 2));
    assign w_accept   = i_in.valid && i_in.ready;

    u8af_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_byte        (i_in.in_byte),
        .o_push        (w_push)
    );

    u8af_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (w_head),
        .o_count (w_fifo_count)
    );

    assign o_out.out_char      = w_head.out_char;
    assign o_out.end_of_string = w_head.end_of_string;

    a_term_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_in.in_byte == CharNul) |=> o_out.valid)
        else $error("terminator transaction not queued after zero byte");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_count <= FifoCntW'(FifoDepth))
        else $error("result queue overflow");

    a_term_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.end_of_string |-> o_out.out_char == CharNul)
        else $error("terminator transaction with nonzero character");

endmodule

>>> dv/tb_utf8_accent_fold_to_ascii.sv
// Testbench for the UTF-8 accent folder: directed and random byte strings checked by a predictor.
module tb_utf8_accent_fold_to_ascii;
    timeunit 1ns;
    timeprecision 1ps;

    import u8af_pkg::*;

    localparam int          LongHold     = 200;
    localparam int          SettleCycles = 4;
    localparam int          CycleLimit   = 400000;
    localparam int          MaxReports   = 10;
    localparam logic [7:0]  Unknown      = "?";
    localparam logic [7:0]  StrEnd       = 8'h00;
    localparam logic [15:0] LimitMax     = 16'hFFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    u8af_in_if  in_ch ();
    u8af_out_if out_ch ();

    utf8_accent_fold_to_ascii dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // folding table: UTF-8 bytes (right aligned) -> base letter
    logic [7:0]  fold_char [bit [23:0]];
    logic [23:0] fold_keys [$];

    // predictor state
    logic [15:0] limit_q   = LimitMax;
    logic [23:0] seq_bytes = '0;
    logic [2:0]  seq_len   = '0;
    logic [1:0]  seq_left  = '0;
    logic [15:0] chars_out = '0;
    t_result     expected_chars [$];

    int unsigned fail_count    = 0;
    int unsigned bytes_sent    = 0;
    int unsigned cycle_count   = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_done    = 0;
    logic        src_gaps      = 1'b1;
    logic        sink_gaps     = 1'b1;

    function automatic logic [23:0] utf8_bytes(input logic [15:0] cp);
        int unsigned c;
        c = cp;
        if (c < 32'h800) return 24'((32'hC0 | (c >> 6)) << 8 | (32'h80 | (c & 32'h3F)));
        return 24'((32'hE0 | (c >> 12)) << 16 | (32'h80 | ((c >> 6) & 32'h3F)) << 8
                   | (32'h80 | (c & 32'h3F)));
    endfunction

    function automatic void add_letters(input logic [7:0] base, input logic [18*16-1:0] cps);
        logic [15:0] cp;
        for (int k = 0; k < 18; k++) begin
            cp = cps[k*16 +: 16];
            if (cp != 16'h0000) begin
                fold_char[utf8_bytes(cp)] = base;
                fold_keys.push_back(utf8_bytes(cp));
            end
        end
    endfunction

    function automatic void build_fold_table();
        add_letters("a", {16'h00E0, 16'h00E1, 16'h1EA3, 16'h00E3, 16'h1EA1, 16'h0103,
                          16'h1EB1, 16'h1EAF, 16'h1EB3, 16'h1EB5, 16'h1EB7, 16'h00E2,
                          16'h1EA7, 16'h1EA5, 16'h1EA9, 16'h1EAB, 16'h1EAD, 16'h00E4});
        add_letters("e", {16'h00E8, 16'h00E9, 16'h1EBB, 16'h1EBD, 16'h1EB9, 16'h00EA,
                          16'h1EC1, 16'h1EBF, 16'h1EC3, 16'h1EC5, 16'h1EC7});
        add_letters("i", {16'h00EC, 16'h00ED, 16'h1EC9, 16'h0129, 16'h1ECB});
        add_letters("o", {16'h00F2, 16'h00F3, 16'h1ECF, 16'h00F5, 16'h1ECD, 16'h00F4,
                          16'h1ED3, 16'h1ED1, 16'h1ED5, 16'h1ED7, 16'h1ED9, 16'h01A1,
                          16'h1EDD, 16'h1EDB, 16'h1EDF, 16'h1EE1, 16'h1EE3, 16'h00F6});
        add_letters("u", {16'h00F9, 16'h00FA, 16'h1EE7, 16'h0169, 16'h1EE5, 16'h01B0,
                          16'h1EEB, 16'h1EE9, 16'h1EED, 16'h1EEF, 16'h1EF1, 16'h00FC});
        add_letters("y", {16'h1EF3, 16'h00FD, 16'h1EF7, 16'h1EF9, 16'h1EF5});
        add_letters("d", {16'h0111});
        add_letters("A", {16'h00C0, 16'h00C1, 16'h1EA2, 16'h00C3, 16'h1EA0, 16'h0102,
                          16'h1EB0, 16'h1EAE, 16'h1EB2, 16'h1EB4, 16'h1EB6, 16'h00C2,
                          16'h1EA6, 16'h1EA4, 16'h1EA8, 16'h1EAA, 16'h1EAC, 16'h00C4});
        add_letters("E", {16'h00C8, 16'h00C9, 16'h1EBA, 16'h1EBC, 16'h1EB8, 16'h00CA,
                          16'h1EC0, 16'h1EBE, 16'h1EC2, 16'h1EC4, 16'h1EC6});
        add_letters("I", {16'h00CC, 16'h00CD, 16'h1EC8, 16'h0128, 16'h1ECA});
        add_letters("O", {16'h00D2, 16'h00D3, 16'h1ECE, 16'h00D5, 16'h1ECC, 16'h00D4,
                          16'h1ED2, 16'h1ED0, 16'h1ED4, 16'h1ED6, 16'h1ED8, 16'h01A0,
                          16'h1EDC, 16'h1EDA, 16'h1EDE, 16'h1EE0, 16'h1EE2, 16'h00D6});
        add_letters("U", {16'h00D9, 16'h00DA, 16'h1EE6, 16'h0168, 16'h1EE4, 16'h01AF,
                          16'h1EEA, 16'h1EE8, 16'h1EEC, 16'h1EEE, 16'h1EF0, 16'h00DC});
        add_letters("Y", {16'h1EF2, 16'h00DD, 16'h1EF6, 16'h1EF8, 16'h1EF4});
        add_letters("D", {16'h0110});
        add_letters("s", {16'h00DF});
        add_letters("c", {16'h00E7});
        add_letters("C", {16'h00C7});
        add_letters("n", {16'h00F1});
        add_letters("N", {16'h00D1});
    endfunction

    function automatic void queue_char(input logic [7:0] c);
        if (chars_out >= limit_q) return;
        chars_out = chars_out + 16'd1;
        expected_chars.push_back('{out_char: c, end_of_string: 1'b0});
    endfunction

    function automatic void fold_byte(input logic [7:0] b);
        logic [2:0] len;
        logic [7:0] c;
        if (b == StrEnd) begin
            if (seq_len != 3'd0) queue_char(Unknown);
            expected_chars.push_back('{out_char: StrEnd, end_of_string: 1'b1});
            seq_bytes = '0;
            seq_len   = '0;
            seq_left  = '0;
            chars_out = '0;
        end else if (seq_len == 3'd0) begin
            len = 3'd1;
            if ((b & 8'hE0) == 8'hC0) len = 3'd2;
            else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
            else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
            if (b < 8'h80) begin
                queue_char(b);
            end else if (len == 3'd1) begin
                queue_char(Unknown);
            end else begin
                seq_bytes = {16'h0000, b};
                seq_len   = len;
                seq_left  = 2'(len - 3'd1);
            end
        end else begin
            // four byte sequences keep only their first three bytes
            if (int'(seq_len) - int'(seq_left) < 3) seq_bytes = {seq_bytes[15:0], b};
            seq_left = seq_left - 2'd1;
            if (seq_left == 2'd0) begin
                if ((seq_len == 3'd2 || seq_len == 3'd3) && fold_char.exists(seq_bytes))
                    c = fold_char[seq_bytes];
                else
                    c = Unknown;
                seq_bytes = '0;
                seq_len   = '0;
                queue_char(c);
            end
        end
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MaxReports) $display("%0t: %s", $realtime, msg);
    endfunction

    // checks results, then predicts from accepted bytes and register writes
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_char: out_ch.out_char, end_of_string: out_ch.end_of_string};
                if (expected_chars.size() == 0) begin
                    note_failure($sformatf("unexpected transaction: char %02h eos %0b",
                                           got.out_char, got.end_of_string));
                end else begin
                    want = expected_chars.pop_front();
                    if (got.out_char !== want.out_char || got.end_of_string !== want.end_of_string)
                        note_failure($sformatf("mismatch: expected char %02h eos %0b, got char %02h eos %0b",
                                               want.out_char, want.end_of_string,
                                               got.out_char, got.end_of_string));
                end
            end
            if (in_ch.valid && in_ch.ready) fold_byte(in_ch.in_byte);
            if (i_cfg_wr_en) limit_q = i_cfg_wr_data;
        end
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CycleLimit);
        $display("CHECKS FAILED");
        $finish;
    end

    // output side: random stalls plus requested long hold-offs
    initial begin
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (holds_done != hold_requests) begin
                out_ch.ready <= 1'b0;
                repeat (LongHold) @(negedge i_clk);
                holds_done++;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (expected_chars.size() != 0);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic test_ascii_passthrough();
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(StrEnd);
        send_byte(StrEnd);
    endtask

    task automatic test_folded_letters();
        send_byte(8'hC3); send_byte(8'hA0);
        // e and E with tilde are three byte forms
        send_byte(8'hE1); send_byte(8'hBA); send_byte(8'hBD);
        send_byte(8'hE1); send_byte(8'hBA); send_byte(8'hBC);
    endtask

    task automatic test_stray_and_broken();
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'hF0); send_byte(8'h9F); send_byte(8'h98); send_byte(8'h80);
        send_byte(8'hC4);
        send_byte(StrEnd);
    endtask

    task automatic test_output_limit();
        write_limit(16'd0);
        send_byte("x");
        send_byte(8'hC3);
        send_byte(StrEnd);
        write_limit(16'd2);
        send_byte("a");
        send_byte("b");
        send_byte("c");
        send_byte(StrEnd);
    endtask

    task automatic test_backpressure();
        wait_drained();
        src_gaps = 1'b0;
        hold_requests++;
        repeat (40) send_byte(8'($urandom_range(1, 127)));
        send_byte(StrEnd);
        wait_drained();
        src_gaps = 1'b1;
    endtask

    task automatic test_random_strings(input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned pick;
        logic [23:0] key;
        logic [7:0]  lead;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            repeat ($urandom_range(0, 12)) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    send_byte(8'($urandom_range(1, 127)));
                end else if (pick < 80) begin
                    key = fold_keys[$urandom_range(0, fold_keys.size() - 1)];
                    if (key[23:16] != 8'h00) send_byte(key[23:16]);
                    send_byte(key[15:8]);
                    send_byte(key[7:0]);
                end else if (pick < 88) begin
                    // 2 or 3 byte lead, continuation bytes of any nonzero value
                    lead = $urandom_range(0, 1) ? 8'($urandom_range(8'hC0, 8'hDF))
                                                : 8'($urandom_range(8'hE0, 8'hEF));
                    send_byte(lead);
                    repeat (lead[5] ? 2 : 1) send_byte(8'($urandom_range(1, 255)));
                end else if (pick < 93) begin
                    send_byte(8'($urandom_range(8'hF0, 8'hF7)));
                    repeat (3) send_byte(8'($urandom_range(8'h80, 8'hBF)));
                end else if (pick < 97) begin
                    send_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                   : 8'($urandom_range(8'hF8, 8'hFF)));
                end else begin
                    // sequence cut short by the end of the string
                    send_byte(8'($urandom_range(8'hE0, 8'hF7)));
                    if ($urandom_range(0, 1)) send_byte(8'($urandom_range(8'h80, 8'hBF)));
                    send_byte(StrEnd);
                end
            end
            send_byte(StrEnd);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        build_fold_table();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_ascii_passthrough();
        test_folded_letters();
        test_stray_and_broken();
        test_output_limit();
        write_limit(LimitMax);
        test_backpressure();
        test_random_strings(260);
        write_limit(16'd0);
        test_random_strings(60);
        write_limit(16'd3);
        test_random_strings(150);
        write_limit(16'd1);
        test_random_strings(60);
        write_limit(16'($urandom_range(2, 12)));
        test_random_strings(120);
        write_limit(LimitMax);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        test_random_strings(200);

        wait_drained();
        repeat (SettleCycles) @(negedge i_clk);
        if (fail_count == 0 && expected_chars.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> utf8_accent_fold_to_ascii.f
rtl/core/u8af_pkg.sv
rtl/core/u8af_in_if.sv
rtl/core/u8af_out_if.sv
rtl/core/u8af_fold_lut.sv
rtl/core/u8af_seq.sv
rtl/core/u8af_out_fifo.sv
rtl/core/utf8_accent_fold_to_ascii.sv
dv/tb_utf8_accent_fold_to_ascii.sv
